>>> hdl/okvt_pkg.sv
// Shared constants, codes and types for the ordered key/value table.
package okvt_pkg;

   // Table geometry
   localparam int CAPACITY    = 16;
   localparam int KEY_WIDTH   = 32;
   localparam int VALUE_WIDTH = 32;

   // Entry index and entry count widths
   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   // Stream field widths
   localparam int OP_W     = 3;
   localparam int KEY_W    = 32;
   localparam int VAL_W    = 32;
   localparam int POS_W    = 4;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   // Position against count compare width
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   // Packed stream widths, rounded up to whole bytes
   localparam int REQ_BITS    = OP_W + KEY_W + VAL_W + POS_W;
   localparam int REQ_TDATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS    = STATUS_W + KEY_W + VAL_W + COUNT_W;
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8;

   // Request operations
   typedef enum logic [OP_W-1:0] {
      OP_INSERT   = 3'd0,
      OP_UPDATE   = 3'd1,
      OP_UPSERT   = 3'd2,
      OP_ERASE    = 3'd3,
      OP_LOOKUP   = 3'd4,
      OP_READ_POS = 3'd5,
      OP_CONTAINS = 3'd6
   } op_type;

   // Response status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_REFUSED = 2'd1,
      ST_FULL    = 2'd2,
      ST_BAD_POS = 2'd3
   } status_type;

endpackage

>>> hdl/ordered_key_value_table.sv
// Ordered key/value table: entry store, scan/shift sequencer and response register.
// Read position and unused ops go from accept to the decision state, then to done; the other
// ops first scan the stored keys, and an insert or upsert of a new key then shifts entries
// up while an erase of a found key shifts entries down, before done.
// One item at a time, the next accepted in the cycle after its response is loaded;
// reset clears the entry count, sequencer and response valid, not the entry store.
module ordered_key_value_table (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // op [2:0], key [34:3], value [66:35], position [70:67], zero pad above
   input  logic [okvt_pkg::REQ_TDATA_W-1:0]   req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // status [1:0], read_key [33:2], read_value [65:34], entry_count [70:66], zero pad above
   output logic [okvt_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);

   // Sequencer states
   typedef enum logic [5:0] {
      S_IDLE       = 6'b000001,
      S_SCAN       = 6'b000010,
      S_EXEC       = 6'b000100,
      S_SHIFT_UP   = 6'b001000,
      S_SHIFT_DOWN = 6'b010000,
      S_DONE       = 6'b100000
   } state_type;

   // Entry store, newest at index 0
   logic [okvt_pkg::KEY_WIDTH-1:0]   key_mem_ff [okvt_pkg::CAPACITY];
   logic [okvt_pkg::VALUE_WIDTH-1:0] val_mem_ff [okvt_pkg::CAPACITY];

   state_type                        state_ff, state_in;
   logic [okvt_pkg::CNT_W-1:0]       count_ff, count_in;
   logic [okvt_pkg::CNT_W-1:0]       idx_ff, idx_in;
   logic [okvt_pkg::IDX_W-1:0]       hit_ff, hit_in;
   logic                             present_ff, present_in;
   okvt_pkg::op_type                 op_ff, op_in;
   logic [okvt_pkg::KEY_WIDTH-1:0]   key_ff, key_in;
   logic [okvt_pkg::VALUE_WIDTH-1:0] val_ff, val_in;
   logic [okvt_pkg::POS_W-1:0]       pos_ff, pos_in;
   okvt_pkg::status_type             res_status_ff, res_status_in;
   logic [okvt_pkg::KEY_WIDTH-1:0]   res_key_ff, res_key_in;
   logic [okvt_pkg::VALUE_WIDTH-1:0] res_val_ff, res_val_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [okvt_pkg::RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   // Request field unpack
   okvt_pkg::op_type                 req_op;
   logic [okvt_pkg::KEY_WIDTH-1:0]   req_key;
   logic [okvt_pkg::VALUE_WIDTH-1:0] req_val;
   logic [okvt_pkg::POS_W-1:0]       req_pos;

   assign req_op  = okvt_pkg::op_type'(req_tdata[okvt_pkg::OP_W-1:0]);
   assign req_key = okvt_pkg::KEY_WIDTH'(req_tdata[okvt_pkg::OP_W +: okvt_pkg::KEY_W]);
   assign req_val = okvt_pkg::VALUE_WIDTH'(
                       req_tdata[okvt_pkg::OP_W + okvt_pkg::KEY_W +: okvt_pkg::VAL_W]);
   assign req_pos = req_tdata[okvt_pkg::OP_W + okvt_pkg::KEY_W + okvt_pkg::VAL_W +:
                              okvt_pkg::POS_W];

   // Handshake
   logic req_fire;
   logic rsp_load;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_load   = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_tready);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Index neighbors and shared store read port
   logic [okvt_pkg::CNT_W-1:0]       idx_m1, idx_p1;
   logic [okvt_pkg::IDX_W-1:0]       rd_addr;
   logic [okvt_pkg::KEY_WIDTH-1:0]   rd_key;
   logic [okvt_pkg::VALUE_WIDTH-1:0] rd_val;

   assign idx_m1 = idx_ff - okvt_pkg::CNT_W'(1);
   assign idx_p1 = idx_ff + okvt_pkg::CNT_W'(1);

   always_comb begin
      unique case (state_ff)
         S_SCAN:       rd_addr = idx_ff[okvt_pkg::IDX_W-1:0];
         S_SHIFT_UP:   rd_addr = idx_m1[okvt_pkg::IDX_W-1:0];
         S_SHIFT_DOWN: rd_addr = idx_p1[okvt_pkg::IDX_W-1:0];
         S_EXEC:       rd_addr = (op_ff == okvt_pkg::OP_READ_POS) ?
                                 okvt_pkg::IDX_W'(pos_ff) : hit_ff;
         default:      rd_addr = hit_ff;
      endcase
   end

   assign rd_key = key_mem_ff[rd_addr];
   assign rd_val = val_mem_ff[rd_addr];

   // Shared compare unit and status flags
   logic key_match, scan_end, pos_ok, table_full, needs_scan;

   assign key_match  = (rd_key == key_ff);
   assign scan_end   = (idx_ff == count_ff);
   assign pos_ok     = okvt_pkg::CMP_W'(pos_ff) < okvt_pkg::CMP_W'(count_ff);
   assign table_full = (count_ff == okvt_pkg::CNT_W'(okvt_pkg::CAPACITY));
   assign needs_scan = (req_op == okvt_pkg::OP_INSERT) || (req_op == okvt_pkg::OP_UPDATE) ||
                       (req_op == okvt_pkg::OP_UPSERT) || (req_op == okvt_pkg::OP_ERASE) ||
                       (req_op == okvt_pkg::OP_LOOKUP) || (req_op == okvt_pkg::OP_CONTAINS);

   // Store write port
   logic                             key_we, val_we;
   logic [okvt_pkg::IDX_W-1:0]       wr_addr;
   logic [okvt_pkg::KEY_WIDTH-1:0]   wr_key;
   logic [okvt_pkg::VALUE_WIDTH-1:0] wr_val;

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      hit_in        = hit_ff;
      present_in    = present_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      val_in        = val_ff;
      pos_in        = pos_ff;
      res_status_in = res_status_ff;
      res_key_in    = res_key_ff;
      res_val_in    = res_val_ff;
      key_we        = 1'b0;
      val_we        = 1'b0;
      wr_addr       = idx_ff[okvt_pkg::IDX_W-1:0];
      wr_key        = rd_key;
      wr_val        = rd_val;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in      = req_op;
               key_in     = req_key;
               val_in     = req_val;
               pos_in     = req_pos;
               idx_in     = '0;
               present_in = 1'b0;
               state_in   = needs_scan ? S_SCAN : S_EXEC;
            end
         end
         // one stored key compared per cycle
         S_SCAN: begin
            if (scan_end) begin
               present_in = 1'b0;
               state_in   = S_EXEC;
            end else if (key_match) begin
               present_in = 1'b1;
               hit_in     = idx_ff[okvt_pkg::IDX_W-1:0];
               state_in   = S_EXEC;
            end else begin
               idx_in = idx_p1;
            end
         end
         // decide on the op once the key is found or known absent
         S_EXEC: begin
            res_status_in = okvt_pkg::ST_OK;
            res_key_in    = '0;
            res_val_in    = '0;
            state_in      = S_DONE;
            unique case (op_ff)
               okvt_pkg::OP_INSERT: begin
                  if (present_ff) begin
                     res_status_in = okvt_pkg::ST_REFUSED;
                  end else if (table_full) begin
                     res_status_in = okvt_pkg::ST_FULL;
                  end else begin
                     idx_in   = count_ff;
                     state_in = S_SHIFT_UP;
                  end
               end
               okvt_pkg::OP_UPDATE: begin
                  if (present_ff) begin
                     val_we  = 1'b1;
                     wr_addr = hit_ff;
                     wr_val  = val_ff;
                  end else begin
                     res_status_in = okvt_pkg::ST_REFUSED;
                  end
               end
               okvt_pkg::OP_UPSERT: begin
                  if (present_ff) begin
                     val_we  = 1'b1;
                     wr_addr = hit_ff;
                     wr_val  = val_ff;
                  end else if (table_full) begin
                     res_status_in = okvt_pkg::ST_FULL;
                  end else begin
                     idx_in   = count_ff;
                     state_in = S_SHIFT_UP;
                  end
               end
               okvt_pkg::OP_ERASE: begin
                  if (present_ff) begin
                     idx_in   = okvt_pkg::CNT_W'(hit_ff);
                     state_in = S_SHIFT_DOWN;
                  end else begin
                     res_status_in = okvt_pkg::ST_REFUSED;
                  end
               end
               okvt_pkg::OP_LOOKUP: begin
                  if (present_ff) begin
                     res_val_in = rd_val;
                  end else begin
                     res_status_in = okvt_pkg::ST_REFUSED;
                  end
               end
               okvt_pkg::OP_READ_POS: begin
                  if (pos_ok) begin
                     res_key_in = rd_key;
                     res_val_in = rd_val;
                  end else begin
                     res_status_in = okvt_pkg::ST_BAD_POS;
                  end
               end
               okvt_pkg::OP_CONTAINS: begin
                  if (!present_ff) begin
                     res_status_in = okvt_pkg::ST_REFUSED;
                  end
               end
               default: begin
                  res_status_in = okvt_pkg::ST_REFUSED;
               end
            endcase
         end
         // move entries one place older, then put the new entry at the front
         S_SHIFT_UP: begin
            key_we = 1'b1;
            val_we = 1'b1;
            if (idx_ff == '0) begin
               wr_key   = key_ff;
               wr_val   = val_ff;
               count_in = count_ff + okvt_pkg::CNT_W'(1);
               state_in = S_DONE;
            end else begin
               idx_in = idx_m1;
            end
         end
         // close the gap left by the erased entry
         S_SHIFT_DOWN: begin
            if (idx_p1 >= count_ff) begin
               count_in = count_ff - okvt_pkg::CNT_W'(1);
               state_in = S_DONE;
            end else begin
               key_we = 1'b1;
               val_we = 1'b1;
               idx_in = idx_p1;
            end
         end
         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = okvt_pkg::RSP_TDATA_W'({okvt_pkg::COUNT_W'(count_ff),
                                                okvt_pkg::VAL_W'(res_val_ff),
                                                okvt_pkg::KEY_W'(res_key_ff),
                                                res_status_ff});
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      hit_ff        <= hit_in;
      present_ff    <= present_in;
      op_ff         <= op_in;
      key_ff        <= key_in;
      val_ff        <= val_in;
      pos_ff        <= pos_in;
      res_status_ff <= res_status_in;
      res_key_ff    <= res_key_in;
      res_val_ff    <= res_val_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // Entry store writes
   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem_ff[wr_addr] <= wr_key;
      end
      if (val_we) begin
         val_mem_ff[wr_addr] <= wr_val;
      end
   end

`ifndef ASSERT_OFF
   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= okvt_pkg::CNT_W'(okvt_pkg::CAPACITY))
      else $error("entry count above capacity");

   a_scan_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (idx_ff <= count_ff))
      else $error("scan index past entry count");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_DONE))
      else $error("response raised outside done state");

   a_count_from_shift: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |->
         (($past(state_ff) == S_SHIFT_UP) || ($past(state_ff) == S_SHIFT_DOWN)))
      else $error("entry count changed outside a shift");
`endif

endmodule

>>> tb/tb_ordered_key_value_table.sv
// Stream-level testbench for the ordered key/value table, checked against its own table model.
`timescale 1ns / 1ps
module tb_ordered_key_value_table;

   // Op code 7 has no operation behind it
   localparam logic [okvt_pkg::OP_W-1:0] OP_UNUSED = 3'd7;
   // Quiet tail after the last response, sized past the worst insert with slack
   localparam int DRAIN_CYCLES = 2 * okvt_pkg::CAPACITY + 8;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 1850;
   localparam int POOL_SIZE    = 20;

   typedef enum int {MIX_FILL, MIX_EVEN, MIX_DRAIN} mix_type;

   // Fields from msb to lsb, so op lands in the lowest bits of tdata
   typedef struct packed {
      logic [okvt_pkg::POS_W-1:0] position;
      logic [okvt_pkg::VAL_W-1:0] value;
      logic [okvt_pkg::KEY_W-1:0] key;
      logic [okvt_pkg::OP_W-1:0]  op;
   } request_type;

   typedef struct packed {
      logic [okvt_pkg::COUNT_W-1:0]  entry_count;
      logic [okvt_pkg::VAL_W-1:0]    read_value;
      logic [okvt_pkg::KEY_W-1:0]    read_key;
      logic [okvt_pkg::STATUS_W-1:0] status;
   } response_type;

   logic                             clock;
   logic                             reset;
   logic                             req_tvalid;
   logic                             req_tready;
   // op [2:0], key [34:3], value [66:35], position [70:67], zero pad above
   logic [okvt_pkg::REQ_TDATA_W-1:0] req_tdata;
   logic                             rsp_tvalid;
   logic                             rsp_tready;
   // status [1:0], read_key [33:2], read_value [65:34], entry_count [70:66], zero pad above
   logic [okvt_pkg::RSP_TDATA_W-1:0] rsp_tdata;

   // Stimulus and expectations
   request_type  pending_q[$];
   response_type expected_q[$];
   logic         req_fire;

   // Model of the table contents, newest entry at index 0
   logic [okvt_pkg::KEY_W-1:0] tbl_key [okvt_pkg::CAPACITY];
   logic [okvt_pkg::VAL_W-1:0] tbl_val [okvt_pkg::CAPACITY];
   int                         tbl_count;

   logic [okvt_pkg::KEY_W-1:0] key_pool [POOL_SIZE];

   int total_items;
   int accepted_count;
   int checked_count;
   int error_count;
   int cycle_count;
   int peak_count;
   int status_seen [4];

   ordered_key_value_table u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Idle phase: receiver-heavy idling, then sender-heavy, then none
   function automatic int idle_phase();
      int ph;
      ph = (total_items > 0) ? (accepted_count * 3) / total_items : 0;
      return (ph > 2) ? 2 : ph;
   endfunction

   function automatic int send_idle_pct();
      case (idle_phase())
         0: return 31;
         1: return 59;
         default: return 0;
      endcase
   endfunction

   function automatic int recv_idle_pct();
      case (idle_phase())
         0: return 59;
         1: return 31;
         default: return 0;
      endcase
   endfunction

   // Apply one request to the table model and return the response it should produce
   function automatic response_type table_response(request_type r);
      response_type res;
      int           hit;
      int           i;
      logic         present;
      hit = tbl_count;
      for (i = 0; i < tbl_count; i++)
         if (hit == tbl_count && tbl_key[i] == r.key)
            hit = i;
      present = (hit < tbl_count);
      res = '0;
      res.status = okvt_pkg::ST_OK;
      case (r.op)
         okvt_pkg::OP_INSERT, okvt_pkg::OP_UPSERT: begin
            if (present && r.op == okvt_pkg::OP_INSERT) begin
               res.status = okvt_pkg::ST_REFUSED;
            end else if (present) begin
               tbl_val[hit] = r.value;
            end else if (tbl_count >= okvt_pkg::CAPACITY) begin
               res.status = okvt_pkg::ST_FULL;
            end else begin
               // new entry goes in front, older ones move back one place
               for (i = tbl_count; i > 0; i--) begin
                  tbl_key[i] = tbl_key[i-1];
                  tbl_val[i] = tbl_val[i-1];
               end
               tbl_key[0] = r.key;
               tbl_val[0] = r.value;
               tbl_count++;
            end
         end
         okvt_pkg::OP_UPDATE: begin
            if (present) tbl_val[hit] = r.value;
            else res.status = okvt_pkg::ST_REFUSED;
         end
         okvt_pkg::OP_ERASE: begin
            if (present) begin
               // close the gap, order kept
               for (i = hit; i < tbl_count - 1; i++) begin
                  tbl_key[i] = tbl_key[i+1];
                  tbl_val[i] = tbl_val[i+1];
               end
               tbl_count--;
            end else begin
               res.status = okvt_pkg::ST_REFUSED;
            end
         end
         okvt_pkg::OP_LOOKUP: begin
            if (present) res.read_value = tbl_val[hit];
            else res.status = okvt_pkg::ST_REFUSED;
         end
         okvt_pkg::OP_READ_POS: begin
            if (int'(r.position) < tbl_count) begin
               res.read_key   = tbl_key[r.position];
               res.read_value = tbl_val[r.position];
            end else begin
               res.status = okvt_pkg::ST_BAD_POS;
            end
         end
         okvt_pkg::OP_CONTAINS:
            res.status = present ? okvt_pkg::ST_OK : okvt_pkg::ST_REFUSED;
         default: res.status = okvt_pkg::ST_REFUSED;
      endcase
      if (tbl_count > peak_count) peak_count = tbl_count;
      res.entry_count = tbl_count[okvt_pkg::COUNT_W-1:0];
      return res;
   endfunction

   // Random request; keys mostly from a small pool so hits and a full table are common
   function automatic request_type random_request(mix_type mix);
      request_type r;
      int          w [8];
      int          roll;
      int          i;
      case (mix)
         MIX_FILL:  w = '{35, 8, 25, 7, 8, 8, 6, 3};
         MIX_DRAIN: w = '{10, 8, 8, 40, 10, 12, 9, 3};
         default:   w = '{14, 13, 14, 14, 14, 14, 14, 3};
      endcase
      roll = $urandom_range(99);
      r.op = OP_UNUSED;
      for (i = 0; i < 8; i++) begin
         if (roll >= 0 && roll < w[i]) r.op = i[okvt_pkg::OP_W-1:0];
         roll = roll - w[i];
      end
      r.key = ($urandom_range(99) < 88) ? key_pool[$urandom_range(POOL_SIZE-1)] : $urandom();
      roll = $urandom_range(99);
      r.value = (roll < 6) ? '0 : (roll < 12) ? '1 : $urandom();
      r.position = okvt_pkg::POS_W'($urandom_range(15));
      return r;
   endfunction

   task automatic queue_request(logic [okvt_pkg::OP_W-1:0] op,
                                logic [okvt_pkg::KEY_W-1:0] key,
                                logic [okvt_pkg::VAL_W-1:0] value,
                                logic [okvt_pkg::POS_W-1:0] position);
      request_type r;
      r.op       = op;
      r.key      = key;
      r.value    = value;
      r.position = position;
      pending_q.push_back(r);
   endtask

   // Driver: new item or idle at the falling edge once the last one was taken
   always @(negedge clock) begin
      request_type next_item;
      logic        next_valid;
      next_item  = request_type'(req_tdata[okvt_pkg::REQ_BITS-1:0]);
      next_valid = req_tvalid;
      if (!reset && (req_fire || !req_tvalid)) begin
         next_valid = 1'b0;
         if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct()) begin
            next_item  = pending_q.pop_front();
            next_valid = 1'b1;
         end
      end
      req_tvalid <= next_valid;
      req_tdata  <= {{(okvt_pkg::REQ_TDATA_W-okvt_pkg::REQ_BITS){1'b0}}, next_item};
      rsp_tready <= !reset && ($urandom_range(99) >= recv_idle_pct());
   end

   // Monitor: predict on each accepted request, check each accepted response
   always @(posedge clock) begin
      response_type got;
      response_type want;
      req_fire <= req_tvalid && req_tready;
      if (!reset && req_tvalid && req_tready) begin
         expected_q.push_back(
            table_response(request_type'(req_tdata[okvt_pkg::REQ_BITS-1:0])));
         accepted_count++;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = response_type'(rsp_tdata[okvt_pkg::RSP_BITS-1:0]);
         if (expected_q.size() == 0) begin
            $error("response item with nothing expected: %h", got);
            error_count++;
         end else begin
            want = expected_q.pop_front();
            checked_count++;
            status_seen[got.status]++;
            if (got.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, got.status);
               error_count++;
            end
            if (got.read_key !== want.read_key) begin
               $error("read_key: expected %h, actual %h", want.read_key, got.read_key);
               error_count++;
            end
            if (got.read_value !== want.read_value) begin
               $error("read_value: expected %h, actual %h", want.read_value, got.read_value);
               error_count++;
            end
            if (got.entry_count !== want.entry_count) begin
               $error("entry_count: expected %0d, actual %0d",
                      want.entry_count, got.entry_count);
               error_count++;
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $error("timeout after %0d cycles, %0d results still expected",
                cycle_count, expected_q.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   // Stimulus, reset and end of run
   initial begin
      mix_type mix;
      int      seg_left;
      int      n;
      clock          = 1'b0;
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      rsp_tready     = 1'b0;
      req_fire       = 1'b0;
      tbl_count      = 0;
      total_items    = 0;
      accepted_count = 0;
      checked_count  = 0;
      error_count    = 0;
      cycle_count    = 0;
      peak_count     = 0;
      status_seen    = '{0, 0, 0, 0};

      key_pool[0] = '0;
      key_pool[1] = '1;
      for (n = 2; n < POOL_SIZE; n++) key_pool[n] = $urandom();

      // Directed: empty table, extremes, every op and refusal case
      queue_request(okvt_pkg::OP_READ_POS, 32'h0, 32'h0, 4'd0);          // bad position
      queue_request(OP_UNUSED,             32'h1234_5678, 32'h0, 4'd0);
      queue_request(okvt_pkg::OP_ERASE,    32'h0, 32'h0, 4'd0);          // absent key
      queue_request(okvt_pkg::OP_UPDATE,   32'hFFFF_FFFF, 32'h1, 4'd0);  // absent key
      queue_request(okvt_pkg::OP_LOOKUP,   32'h0, 32'h0, 4'd0);          // absent key
      queue_request(okvt_pkg::OP_CONTAINS, 32'h0, 32'h0, 4'd0);          // absent key
      queue_request(okvt_pkg::OP_INSERT,   32'h0, 32'hFFFF_FFFF, 4'd0);
      queue_request(okvt_pkg::OP_INSERT,   32'hFFFF_FFFF, 32'h0, 4'd0);
      queue_request(okvt_pkg::OP_INSERT,   32'h0, 32'h5555_5555, 4'd0);  // duplicate key
      queue_request(okvt_pkg::OP_UPSERT,   32'hFFFF_FFFF, 32'hA5A5_A5A5, 4'd0); // update
      queue_request(okvt_pkg::OP_UPSERT,   32'h1234_5678, 32'h8765_4321, 4'd0); // insert
      queue_request(okvt_pkg::OP_LOOKUP,   32'h0, 32'h0, 4'd0);
      queue_request(okvt_pkg::OP_CONTAINS, 32'hFFFF_FFFF, 32'h0, 4'd0);
      queue_request(okvt_pkg::OP_READ_POS, 32'h0, 32'h0, 4'd0);
      queue_request(okvt_pkg::OP_READ_POS, 32'h0, 32'h0, 4'd2);
      queue_request(okvt_pkg::OP_READ_POS, 32'h0, 32'h0, 4'd3);          // at entry count
      queue_request(okvt_pkg::OP_READ_POS, 32'h0, 32'h0, 4'd15);
      queue_request(okvt_pkg::OP_UPDATE,   32'h0, 32'h0, 4'd0);
      queue_request(okvt_pkg::OP_ERASE,    32'hFFFF_FFFF, 32'h0, 4'd0);  // middle entry
      queue_request(okvt_pkg::OP_READ_POS, 32'h0, 32'h0, 4'd1);
      queue_request(okvt_pkg::OP_LOOKUP,   32'hFFFF_FFFF, 32'h0, 4'd0);

      // Fill to capacity and past it, then probe the full table
      for (n = 2; n < POOL_SIZE; n++)
         queue_request(okvt_pkg::OP_INSERT, key_pool[n], $urandom(), 4'd0);
      queue_request(okvt_pkg::OP_UPSERT,   $urandom(), $urandom(), 4'd0);
      queue_request(okvt_pkg::OP_READ_POS, 32'h0, 32'h0, 4'd15);
      queue_request(okvt_pkg::OP_READ_POS, 32'h0, 32'h0, 4'd0);

      // Random: segments alternating between filling, even and draining mixes
      mix = MIX_DRAIN;
      seg_left = 0;
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (seg_left == 0) begin
            mix = (mix == MIX_FILL) ? MIX_EVEN : (mix == MIX_EVEN) ? MIX_DRAIN : MIX_FILL;
            seg_left = $urandom_range(30, 80);
         end
         pending_q.push_back(random_request(mix));
         seg_left--;
      end
      total_items = pending_q.size();

      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // Wait for all requests taken and all responses checked, then a quiet tail
      while (pending_q.size() != 0 || req_tvalid || expected_q.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Checked %0d responses: ok %0d, refused %0d, full %0d, bad position %0d",
               checked_count, status_seen[okvt_pkg::ST_OK], status_seen[okvt_pkg::ST_REFUSED],
               status_seen[okvt_pkg::ST_FULL], status_seen[okvt_pkg::ST_BAD_POS]);
      $display("Peak table occupancy %0d of %0d entries, %0d mismatches",
               peak_count, okvt_pkg::CAPACITY, error_count);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

>>> files.f
hdl/okvt_pkg.sv
hdl/ordered_key_value_table.sv
tb/tb_ordered_key_value_table.sv
